// ===== sv/string_to_integer_parser_unit_defines.svh =====
// assertion macros shared by the parser modules
`ifndef STRING_TO_INTEGER_PARSER_UNIT_DEFINES_SVH
`define STRING_TO_INTEGER_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define STIP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stip assertion failed");

// condition must never be true
`define STIP_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("stip assertion failed");

`else

`define STIP_ASSERT_IMPLY(label, ante, cons)
`define STIP_ASSERT_NEVER(label, expr)

`endif

`endif

// ===== sv/stip_pkg.sv =====
`default_nettype none

package stip_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_OFFSET_DEF  = 4095;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CH_W         = 8;
    localparam int RADIX_W      = 6;
    localparam int DIGIT_W      = 6;
    localparam int OUT_OFFSET_W = 12;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [DIGIT_W-1:0] NO_DIGIT    = 6'd63;

    // one classified character word
    typedef struct packed {
        logic                first;
        logic                is_space;
        logic                is_sign;
        logic                is_minus;
        logic                is_zero;
        logic                is_x;
        logic [DIGIT_W-1:0]  digit;
        logic [RADIX_W-1:0]  radix;
    } entry_t;

endpackage

`default_nettype wire

// ===== sv/stip_front.sv =====
`default_nettype none

module stip_front
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [stip_pkg::CH_W-1:0]          ch,
    input  wire logic                               first,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [stip_pkg::RADIX_W-1:0]       radix,
    input  wire logic                               q_full,
    output logic                                    push,
    output stip_pkg::entry_t                        push_entry
);

    localparam logic [7:0] CH_TAB        = 8'd9;
    localparam logic [7:0] CH_CR         = 8'd13;
    localparam logic [7:0] CH_SPACE      = 8'd32;
    localparam logic [7:0] CH_PLUS       = 8'd43;
    localparam logic [7:0] CH_MINUS      = 8'd45;
    localparam logic [7:0] CH_0          = 8'd48;
    localparam logic [7:0] CH_9          = 8'd57;
    localparam logic [7:0] CH_UA         = 8'd65;
    localparam logic [7:0] CH_UZ         = 8'd90;
    localparam logic [7:0] CH_LA         = 8'd97;
    localparam logic [7:0] CH_LZ         = 8'd122;
    localparam logic [7:0] CH_UX         = 8'd88;
    localparam logic [7:0] CH_LX         = 8'd120;
    localparam logic [7:0] UPPER_BASE    = 8'd55;  // 'A' - 10
    localparam logic [7:0] LOWER_BASE    = 8'd87;  // 'a' - 10

    logic [stip_pkg::RADIX_W-1:0] radix_reg;
    logic [stip_pkg::RADIX_W-1:0] radix_next;
    logic [7:0]                   digit_full;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign push      = in_valid && in_ready;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_valid)
        begin
            radix_next = radix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= stip_pkg::RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // digit value of the character, no-digit code otherwise
    always_comb
    begin
        digit_full = {2'b00, stip_pkg::NO_DIGIT};
        if (ch >= CH_0 && ch <= CH_9)
        begin
            digit_full = ch - CH_0;
        end
        else if (ch >= CH_UA && ch <= CH_UZ)
        begin
            digit_full = ch - UPPER_BASE;
        end
        else if (ch >= CH_LA && ch <= CH_LZ)
        begin
            digit_full = ch - LOWER_BASE;
        end
    end

    always_comb
    begin
        push_entry.first    = first;
        push_entry.is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        push_entry.is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
        push_entry.is_minus = (ch == CH_MINUS);
        push_entry.is_zero  = (ch == CH_0);
        push_entry.is_x     = (ch == CH_UX) || (ch == CH_LX);
        push_entry.digit    = digit_full[stip_pkg::DIGIT_W-1:0];
        push_entry.radix    = radix_reg;
    end

endmodule

`default_nettype wire

// ===== sv/stip_queue.sv =====
`default_nettype none

`include "string_to_integer_parser_unit_defines.svh"

module stip_queue
#(
    parameter int DEPTH = stip_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire stip_pkg::entry_t   push_entry,
    input  wire logic               pop,
    output stip_pkg::entry_t        head,
    output logic                    empty,
    output logic                    full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stip_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `STIP_ASSERT_NEVER(a_no_push_full, push && full)
    `STIP_ASSERT_NEVER(a_no_pop_empty, pop && empty)
    `STIP_ASSERT_IMPLY(a_ptr_match, empty || full, wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

// ===== sv/stip_back.sv =====
`default_nettype none

`include "string_to_integer_parser_unit_defines.svh"

module stip_back
#(
    parameter int VALUE_WIDTH = stip_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_OFFSET  = stip_pkg::MAX_OFFSET_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire stip_pkg::entry_t                       head,
    input  wire logic                                   q_empty,
    output logic                                        pop,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [VALUE_WIDTH-1:0]               value,
    output logic [stip_pkg::OUT_OFFSET_W-1:0]           end_offset,
    output logic                                        overflow,
    output logic                                        got_digits
);

    localparam int OFFSET_W = $clog2(MAX_OFFSET + 1);
    localparam int EXT_W    = (OFFSET_W > stip_pkg::OUT_OFFSET_W) ? OFFSET_W
                                                                  : stip_pkg::OUT_OFFSET_W;
    localparam int PROD_W   = VALUE_WIDTH + 7;
    localparam int RW       = stip_pkg::RADIX_W;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SPACE  = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_HEXPFX = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    localparam logic [RW-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RW-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RW-1:0] RADIX_MAX  = 6'd36;
    localparam logic [RW-1:0] RADIX_8    = 6'd8;
    localparam logic [RW-1:0] RADIX_10   = 6'd10;
    localparam logic [RW-1:0] RADIX_16   = 6'd16;

    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = ~VAL_MIN;
    localparam logic [PROD_W-1:0]      HALF    = PROD_W'(VAL_MIN);
    localparam logic [OFFSET_W-1:0]    POS_MAX = OFFSET_W'(MAX_OFFSET);

    logic [2:0]              phase_reg;
    logic [2:0]              phase_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [VALUE_WIDTH-1:0]  acc_reg;
    logic [VALUE_WIDTH-1:0]  acc_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    seen_reg;
    logic                    seen_next;
    logic [RW-1:0]           ar_reg;
    logic [RW-1:0]           ar_next;
    logic [OFFSET_W-1:0]     pos_reg;
    logic [OFFSET_W-1:0]     pos_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [VALUE_WIDTH-1:0]  value_reg;
    logic [VALUE_WIDTH-1:0]  value_next;
    logic [stip_pkg::OUT_OFFSET_W-1:0] end_reg;
    logic [stip_pkg::OUT_OFFSET_W-1:0] end_next;
    logic                    ovf_out_reg;
    logic                    ovf_out_next;
    logic                    got_reg;
    logic                    got_next;

    logic                    active;
    logic [2:0]              ph_cur;
    logic [OFFSET_W-1:0]     pos_cur;
    logic [OFFSET_W-1:0]     pos_prev;
    logic [RW-1:0]           ar_cur;
    logic [VALUE_WIDTH-1:0]  acc_cur;
    logic                    signed_path;
    logic                    digit_path;
    logic                    digit_ok;
    logic                    emit;
    logic [OFFSET_W-1:0]     emit_pos;
    logic [EXT_W-1:0]        pos_ext;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       limit;

    assign pop        = !q_empty && (!out_valid_reg || out_ready);
    assign active     = head.first || (phase_reg != PH_IDLE);
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign end_offset = end_reg;
    assign overflow   = ovf_out_reg;
    assign got_digits = got_reg;

    always_comb
    begin
        // a new string restarts the context in the same cycle
        ph_cur   = head.first ? PH_SPACE : phase_reg;
        ar_cur   = head.first ? head.radix : ar_reg;
        acc_cur  = head.first ? '0 : acc_reg;
        pos_prev = head.first ? '0 : pos_reg;
        pos_cur  = head.first ? '0 : ((pos_reg < POS_MAX) ? pos_reg + OFFSET_W'(1) : pos_reg);

        phase_next  = phase_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        seen_next   = seen_reg;
        ar_next     = ar_reg;
        pos_next    = pos_reg;
        signed_path = 1'b0;
        digit_path  = 1'b0;
        digit_ok    = 1'b0;
        emit        = 1'b0;
        emit_pos    = pos_cur;
        prod        = '0;
        limit       = '0;

        if (pop && active)
        begin
            phase_next = ph_cur;
            neg_next   = head.first ? 1'b0 : neg_reg;
            acc_next   = acc_cur;
            ovf_next   = head.first ? 1'b0 : ovf_reg;
            seen_next  = head.first ? 1'b0 : seen_reg;
            ar_next    = ar_cur;
            pos_next   = pos_cur;

            case (ph_cur)
                PH_SPACE:
                begin
                    if (head.is_space)
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (head.is_sign)
                    begin
                        neg_next   = head.is_minus;
                        phase_next = PH_SIGNED;
                    end
                    else
                    begin
                        signed_path = 1'b1;
                    end
                end
                PH_SIGNED:
                begin
                    signed_path = 1'b1;
                end
                PH_ZERO:
                begin
                    if (head.is_x)
                    begin
                        phase_next = PH_HEXPFX;
                    end
                    else
                    begin
                        if (ar_cur == RADIX_AUTO)
                        begin
                            ar_next = RADIX_8;
                        end
                        phase_next = PH_DIGITS;
                        digit_path = 1'b1;
                    end
                end
                PH_HEXPFX:
                begin
                    ar_next    = RADIX_16;
                    phase_next = PH_DIGITS;
                    digit_path = 1'b1;
                    // a bare prefix ends at the x
                    emit_pos   = pos_prev;
                end
                PH_DIGITS:
                begin
                    digit_path = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (signed_path)
            begin
                if (head.is_zero && (ar_cur == RADIX_AUTO || ar_cur == RADIX_16))
                begin
                    seen_next  = 1'b1;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    if (ar_cur == RADIX_AUTO)
                    begin
                        ar_next = RADIX_10;
                    end
                    phase_next = PH_DIGITS;
                    digit_path = 1'b1;
                end
            end

            if (digit_path)
            begin
                digit_ok = (ar_next >= RADIX_MIN) && (ar_next <= RADIX_MAX)
                           && (head.digit < ar_next);
                if (digit_ok)
                begin
                    seen_next = 1'b1;
                    prod  = PROD_W'(acc_cur) * PROD_W'(ar_next) + PROD_W'(head.digit);
                    limit = neg_next ? HALF : HALF - PROD_W'(1);
                    if (ovf_next || prod > limit)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = prod[VALUE_WIDTH-1:0];
                    end
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    assign pos_ext = EXT_W'(emit_pos);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        end_next       = end_reg;
        ovf_out_next   = ovf_out_reg;
        got_next       = got_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (!seen_next)
            begin
                value_next = '0;
            end
            else if (ovf_next)
            begin
                value_next = neg_next ? VAL_MIN : VAL_MAX;
            end
            else
            begin
                value_next = neg_next ? '0 - acc_next : acc_next;
            end
            end_next     = seen_next ? pos_ext[stip_pkg::OUT_OFFSET_W-1:0] : '0;
            ovf_out_next = ovf_next;
            got_next     = seen_next;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            ar_reg        <= stip_pkg::RADIX_RESET;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            seen_reg      <= seen_next;
            ar_reg        <= ar_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        end_reg     <= end_next;
        ovf_out_reg <= ovf_out_next;
        got_reg     <= got_next;
    end

    `STIP_ASSERT_IMPLY(a_no_digit_result, out_valid_reg && !got_reg, value_reg == '0 && end_reg == '0 && !ovf_out_reg)
    `STIP_ASSERT_IMPLY(a_ovf_saturated, out_valid_reg && ovf_out_reg, value_reg == VAL_MIN || value_reg == VAL_MAX)
    `STIP_ASSERT_IMPLY(a_acc_in_range, !ovf_reg, acc_reg <= VAL_MIN)

endmodule

`default_nettype wire

// ===== sv/string_to_integer_parser_unit.sv =====
// result path: the terminating character is written into the queue, popped by the back end
//   sequencer and then registered at the output; a held result stalls the pop
// throughput: one character word per cycle, unless a full queue or a held result stalls, set by
//   the combinational multiply-add and limit compare in the back end sequencer
// a queue (4 entries by default) between classifier and sequencer lets each side stall on its own
// reset: asynchronous, active low; radix returns to 10, parser idle, queue and output empty
`default_nettype none

module string_to_integer_parser_unit
#(
    parameter int VALUE_WIDTH = stip_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_OFFSET  = stip_pkg::MAX_OFFSET_DEF,
    parameter int QUEUE_DEPTH = stip_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [stip_pkg::CH_W-1:0]          ch,
    input  wire logic                               first,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [stip_pkg::RADIX_W-1:0]       radix,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [VALUE_WIDTH-1:0]           value,
    output logic [stip_pkg::OUT_OFFSET_W-1:0]       end_offset,
    output logic                                    overflow,
    output logic                                    got_digits
);

    stip_pkg::entry_t push_entry;
    stip_pkg::entry_t head;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;

    stip_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .first      (first),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .radix      (radix),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    stip_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    stip_back
    #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_OFFSET  (MAX_OFFSET)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .end_offset (end_offset),
        .overflow   (overflow),
        .got_digits (got_digits)
    );

endmodule

`default_nettype wire

// ===== tb/string_to_integer_parser_unit_test.sv =====
`default_nettype none

module string_to_integer_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W      = 32;
    localparam int OFFSET_LIMIT = 4095;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 170;
    localparam int LONG_HOLD    = 400;
    localparam int LONG_SPACES  = 4100;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_SPACE,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_PREFIX,
        SCAN_DIGITS
    } scan_phase_t;

    typedef struct packed {
        logic [stip_pkg::CH_W-1:0] code;
        logic                      lead;
    } char_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]          value;
        logic [stip_pkg::OUT_OFFSET_W-1:0]  end_offset;
        logic                               overflow;
        logic                               got_digits;
    } parse_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [stip_pkg::CH_W-1:0]           ch = '0;
    logic                                first = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [stip_pkg::RADIX_W-1:0]        radix = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [VALUE_W-1:0]           value;
    logic [stip_pkg::OUT_OFFSET_W-1:0]   end_offset;
    logic                                overflow;
    logic                                got_digits;

    // shadow of the parser state
    logic [stip_pkg::RADIX_W-1:0]        radix_setting = stip_pkg::RADIX_RESET;
    scan_phase_t                         scan_phase = SCAN_IDLE;
    logic                                is_negative = 1'b0;
    logic [63:0]                         magnitude = '0;
    logic                                saturated = 1'b0;
    logic                                have_digit = 1'b0;
    logic [stip_pkg::RADIX_W-1:0]        string_radix = stip_pkg::RADIX_RESET;
    logic [stip_pkg::OUT_OFFSET_W-1:0]   char_pos = '0;

    char_word_t                          pending_chars[$];
    parse_result_t                       expected_results[$];
    char_word_t                          drive_word;
    parse_result_t                       oldest;

    int error_count  = 0;
    int items_queued = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int hold_left    = 0;
    int cycle_count  = 0;
    bit next_first   = 1'b0;
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    bit in_taken     = 1'b0;

    string_to_integer_parser_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .first      (first),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .radix      (radix),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .end_offset (end_offset),
        .overflow   (overflow),
        .got_digits (got_digits)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [stip_pkg::DIGIT_W-1:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 6'(c - "0");
        if (c >= "A" && c <= "Z")
            return 6'(c - "A" + 8'd10);
        if (c >= "a" && c <= "z")
            return 6'(c - "a" + 8'd10);
        return stip_pkg::NO_DIGIT;
    endfunction

    function automatic bit digit_fits(input logic [5:0] d, input logic [5:0] base);
        return base >= 6'd2 && base <= 6'd36 && d < base;
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
            return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    task automatic accumulate_digit(input logic [5:0] d);
        logic [63:0] base;
        logic [63:0] limit;
        logic [63:0] cutoff;
        logic [63:0] cutlim;
        base = 64'(string_radix);
        have_digit = 1'b1;
        if (base < 2)
            return;
        limit = is_negative ? (64'd1 << (VALUE_W - 1)) : (64'd1 << (VALUE_W - 1)) - 64'd1;
        cutoff = limit / base;
        cutlim = limit % base;
        if (saturated || magnitude > cutoff || (magnitude == cutoff && 64'(d) > cutlim))
            saturated = 1'b1;
        else
            magnitude = magnitude * base + 64'(d);
    endtask

    task automatic close_string(input logic [11:0] end_pos);
        parse_result_t r;
        if (!have_digit)
            r.value = '0;
        else if (saturated)
            r.value = is_negative ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        else
            r.value = is_negative ? VALUE_W'(64'd0 - magnitude) : VALUE_W'(magnitude);
        r.end_offset = have_digit ? end_pos : '0;
        r.overflow   = saturated;
        r.got_digits = have_digit;
        expected_results.push_back(r);
        scan_phase = SCAN_IDLE;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic lead);
        logic [11:0] prev_pos;
        logic [5:0]  d;
        if (lead)
        begin
            scan_phase   = SCAN_SPACE;
            is_negative  = 1'b0;
            magnitude    = '0;
            saturated    = 1'b0;
            have_digit   = 1'b0;
            string_radix = radix_setting;
            char_pos     = '0;
            prev_pos     = '0;
        end
        else
        begin
            if (scan_phase == SCAN_IDLE)
                return;
            prev_pos = char_pos;
            if (char_pos < OFFSET_LIMIT)
                char_pos = char_pos + 1'b1;
        end
        d = digit_value(c);
        case (scan_phase)
            SCAN_SPACE, SCAN_SIGN:
            begin
                if (scan_phase == SCAN_SPACE && (c == " " || (c >= 8'd9 && c <= 8'd13)))
                    return;
                if (scan_phase == SCAN_SPACE && (c == "-" || c == "+"))
                begin
                    is_negative = (c == "-");
                    scan_phase = SCAN_SIGN;
                    return;
                end
                if (c == "0" && (string_radix == 6'd0 || string_radix == 6'd16))
                begin
                    have_digit = 1'b1;
                    scan_phase = SCAN_ZERO;
                    return;
                end
                if (string_radix == 6'd0)
                    string_radix = 6'd10;
                if (!digit_fits(d, string_radix))
                begin
                    close_string(char_pos);
                    return;
                end
                accumulate_digit(d);
                scan_phase = SCAN_DIGITS;
            end
            SCAN_ZERO:
            begin
                if (c == "x" || c == "X")
                begin
                    scan_phase = SCAN_PREFIX;
                    return;
                end
                if (string_radix == 6'd0)
                    string_radix = 6'd8;
                scan_phase = SCAN_DIGITS;
                if (!digit_fits(d, string_radix))
                    close_string(char_pos);
                else
                    accumulate_digit(d);
            end
            SCAN_PREFIX:
            begin
                string_radix = 6'd16;
                // bare prefix: the offset points back at the x
                if (!digit_fits(d, 6'd16))
                begin
                    close_string(prev_pos);
                    return;
                end
                accumulate_digit(d);
                scan_phase = SCAN_DIGITS;
            end
            SCAN_DIGITS:
            begin
                if (!digit_fits(d, string_radix))
                    close_string(char_pos);
                else
                    accumulate_digit(d);
            end
            default:
                scan_phase = SCAN_IDLE;
        endcase
    endtask

    task automatic push_char(input logic [7:0] c);
        pending_chars.push_back('{c, next_first});
        next_first = 1'b0;
        items_queued++;
    endtask

    task automatic queue_text(input string s);
        next_first = 1'b1;
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    task automatic queue_number();
        string seps = " ;,.\n:";
        int    base;
        int    n;
        int    r;
        next_first = 1'b1;
        base = radix_setting;
        n = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
        repeat (n)
            push_char(($urandom_range(0, 5) == 0) ? 8'd32 : 8'($urandom_range(9, 13)));
        r = $urandom_range(0, 3);
        if (r == 0)
            push_char("-");
        else if (r == 1)
            push_char("+");
        if (base == 0 || base == 16)
        begin
            r = $urandom_range(0, 3);
            if (r == 0)
            begin
                push_char("0");
                push_char($urandom_range(0, 1) ? "x" : "X");
                base = 16;
            end
            else if (r == 1)
            begin
                push_char("0");
                if (base == 0)
                    base = 8;
            end
            else if (base == 0)
                base = 10;
        end
        // no base fits: throw any letters and digits at it
        if (base < 2 || base > 36)
            base = 36;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 36) : $urandom_range(0, 7);
        repeat (n)
        begin
            if ($urandom_range(0, 49) == 0)
                next_first = 1'b1;
            if ($urandom_range(0, 39) == 0)
                push_char(8'($urandom));
            else
                push_char(digit_char($urandom_range(0, base - 1)));
        end
        r = $urandom_range(0, 9);
        if (r >= 1 && r <= 3)
            push_char(8'($urandom));
        else if (r > 3)
            push_char(seps[$urandom_range(0, seps.len() - 1)]);
        // trailing bytes, mostly ignored while idle
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
                push_char(8'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_radix(input logic [stip_pkg::RADIX_W-1:0] v);
        @(negedge clk);
        radix <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        radix_setting = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // input word driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap = send_gap - 1;
                end
                else if (pending_chars.size() != 0)
                begin
                    drive_word = pending_chars.pop_front();
                    in_valid <= 1'b1;
                    ch <= drive_word.code;
                    first <= drive_word.lead;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 16);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            in_taken = 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap = recv_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0)
                recv_gap = $urandom_range(1, 16);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected: value %0d", value);
                    error_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (value !== oldest.value)
                    begin
                        $error("value: expected %0d, got %0d", oldest.value, value);
                        error_count++;
                    end
                    if (end_offset !== oldest.end_offset)
                    begin
                        $error("end_offset: expected %0d, got %0d", oldest.end_offset, end_offset);
                        error_count++;
                    end
                    if (overflow !== oldest.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", oldest.overflow, overflow);
                        error_count++;
                    end
                    if (got_digits !== oldest.got_digits)
                    begin
                        $error("got_digits: expected %0b, got %0b", oldest.got_digits, got_digits);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                parse_char(ch, first);
                in_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** string_to_integer_parser_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [stip_pkg::RADIX_W-1:0] settings[10];
        int target;
        int waited;
        settings = '{6'd10, 6'd0, 6'd16, 6'd2, 6'd36, 6'd8, 6'd1, 6'd63, 6'd7, 6'd10};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // radix from reset: whitespace, sign, terminator, idle byte, restart, limits; then radix 0, 1 and 36
        queue_text("\t-7z");
        push_char("5");
        queue_text("9");
        queue_text("+1;");
        queue_text("x");
        queue_text("2147483647,");
        queue_text("-2147483649 ");
        wait_idle();
        write_radix(6'd0);
        queue_text("0x1G");
        queue_text("0x!");
        queue_text("017 ");
        wait_idle();
        write_radix(6'd1);
        queue_text("5.");
        wait_idle();
        write_radix(6'd36);
        queue_text("-Zz.");

        for (int p = 0; p < 10; p++)
        begin
            wait_idle();
            write_radix(settings[p]);
            if (p == 0)
            begin
                // output held off while short strings keep coming
                hold_request = 1'b1;
                repeat (80)
                begin
                    next_first = 1'b1;
                    push_char(digit_char($urandom_range(0, 9)));
                    push_char(";");
                end
            end
            if (p == 9)
            begin
                // offset saturation on a very long run of spaces
                next_first = 1'b1;
                repeat (LONG_SPACES) push_char(" ");
                push_char("7");
                push_char("#");
                wait_idle();
                quiet = 1'b1;
            end
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target)
                queue_number();
        end

        waited = 0;
        while ((pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
               && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        if (pending_chars.size() != 0 || in_valid)
        begin
            $error("%0d input words never accepted", pending_chars.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** string_to_integer_parser_unit: PASSED **");
        else
            $display("** string_to_integer_parser_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
